### design/pdms_pkg.sv
package pdms_pkg;

    // Field and store widths.
    localparam int PIXELS       = 4096;
    localparam int PIXEL_BITS   = $clog2(PIXELS);
    localparam int SAMPLE_BITS  = 16;
    localparam int S1_BITS      = 28;
    localparam int S2_BITS      = 42;
    localparam int N_BITS       = 11;
    localparam int MAX_FRAMES   = 1024;
    localparam int PROD_BITS    = 2 * SAMPLE_BITS;

    // Finalize engine sizing.
    localparam int DIV_BITS     = 2 * S1_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
    localparam int SQRT_STEPS   = S2_BITS / 2;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

    // Per-pixel statistics as held in the store.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] ref_val;
        logic [S1_BITS-1:0]     s1;
        logic [S2_BITS-1:0]     s2;
    } pixel_stats_t;

    // One finalize request passed from the front end to the back end.
    typedef struct packed {
        logic [PIXEL_BITS-1:0] pix;
        pixel_stats_t          stats;
    } fin_entry_t;

endpackage

### design/pdms_fifo.sv
module pdms_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pdms_pkg::fin_entry_t wr_data,
    input  logic                 pop,
    output pdms_pkg::fin_entry_t rd_data,
    output logic                 full,
    output logic                 empty
);

    pdms_pkg::fin_entry_t           slot_reg [pdms_pkg::FIFO_DEPTH];
    logic [pdms_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [pdms_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [pdms_pkg::FIFO_AW:0]     count_reg;

    assign full    = (count_reg == (pdms_pkg::FIFO_AW+1)'(pdms_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("item queue written while full");
    assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
        else $error("item queue read while empty");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("item queue count did not follow a write");

endmodule

### design/pdms_front.sv
module pdms_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                op,
    input  logic [pdms_pkg::PIXEL_BITS-1:0]     pixel_index,
    input  logic [pdms_pkg::SAMPLE_BITS-1:0]    sample,
    input  logic                                first_frame,
    input  logic                                fifo_full,
    output logic                                fifo_push,
    output pdms_pkg::fin_entry_t                fifo_data
);

    pdms_pkg::pixel_stats_t                 mem [pdms_pkg::PIXELS];
    pdms_pkg::pixel_stats_t                 rd_reg;
    logic                                   st_valid_reg;
    logic                                   st_op_reg;
    logic                                   st_first_reg;
    logic [pdms_pkg::PIXEL_BITS-1:0]        st_pix_reg;
    logic [pdms_pkg::SAMPLE_BITS-1:0]       st_sample_reg;
    logic                                   fwd_valid_reg;
    logic [pdms_pkg::PIXEL_BITS-1:0]        fwd_pix_reg;
    pdms_pkg::pixel_stats_t                 fwd_reg;
    pdms_pkg::pixel_stats_t                 cur;
    pdms_pkg::pixel_stats_t                 upd;
    logic                                   accept;
    logic                                   advance;
    logic                                   wr_en;
    logic signed [pdms_pkg::SAMPLE_BITS:0]  diff;
    logic [pdms_pkg::SAMPLE_BITS-1:0]       abs_diff;
    logic [pdms_pkg::PROD_BITS-1:0]         sq;

    // Handshake: the stage empties unless a finalize item meets a full queue.
    assign advance  = st_valid_reg && (!st_op_reg || !fifo_full);
    assign in_ready = !st_valid_reg || advance;
    assign accept   = in_valid && in_ready;
    assign wr_en    = advance && !st_op_reg;

    // The most recent write overrides the store read for the same pixel.
    assign cur = (fwd_valid_reg && (fwd_pix_reg == st_pix_reg)) ? fwd_reg : rd_reg;

    // Accumulate update.
    always_comb
    begin
        diff     = $signed({1'b0, st_sample_reg}) - $signed({1'b0, cur.ref_val});
        abs_diff = diff[pdms_pkg::SAMPLE_BITS] ? pdms_pkg::SAMPLE_BITS'(-diff)
                                               : diff[pdms_pkg::SAMPLE_BITS-1:0];
        sq       = abs_diff * abs_diff;
        if (st_first_reg)
        begin
            upd.ref_val = st_sample_reg;
            upd.s1      = '0;
            upd.s2      = '0;
        end
        else
        begin
            upd.ref_val = cur.ref_val;
            upd.s1      = cur.s1 + {{(pdms_pkg::S1_BITS-pdms_pkg::SAMPLE_BITS-1)
                                     {diff[pdms_pkg::SAMPLE_BITS]}}, diff};
            upd.s2      = cur.s2 + {{(pdms_pkg::S2_BITS-pdms_pkg::PROD_BITS){1'b0}}, sq};
        end
    end

    assign fifo_push       = st_valid_reg && st_op_reg && !fifo_full;
    assign fifo_data.pix   = st_pix_reg;
    assign fifo_data.stats = cur;

    // Stage control and forwarding register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                st_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                st_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_op_reg     <= op;
            st_first_reg  <= first_frame;
            st_pix_reg    <= pixel_index;
            st_sample_reg <= sample;
        end
        if (wr_en)
        begin
            fwd_pix_reg <= st_pix_reg;
            fwd_reg     <= upd;
        end
    end

    // Statistics store: read on accept, written when an accumulate item retires.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[st_pix_reg] <= upd;
        end
        if (accept)
        begin
            rd_reg <= mem[pixel_index];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) (st_valid_reg && !advance) |-> !in_ready)
        else $error("item accepted while the stage is blocked");
    assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> !fifo_push)
        else $error("store write and queue write for the same item");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_valid_reg && !advance) |=> (st_valid_reg && $stable(st_pix_reg)))
        else $error("blocked item lost");

endmodule

### design/pdms_back.sv
module pdms_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [pdms_pkg::N_BITS-1:0]         num_frames,
    input  logic                                fifo_empty,
    input  pdms_pkg::fin_entry_t                fifo_data,
    output logic                                fifo_pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pdms_pkg::PIXEL_BITS-1:0]     result_pixel,
    output logic [pdms_pkg::SAMPLE_BITS-1:0]    mean_value,
    output logic [pdms_pkg::SAMPLE_BITS-1:0]    std_value
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_MEAN,
        S_MEAN,
        S_DIV_Q,
        S_VAR,
        S_DIV_V,
        S_SQRT,
        S_DONE
    } state_t;

    localparam int MEAN_BITS = pdms_pkg::S1_BITS + 2;

    state_t                                 state_reg;
    logic [pdms_pkg::PIXEL_BITS-1:0]        pix_reg;
    logic [pdms_pkg::SAMPLE_BITS-1:0]       ref_reg;
    logic                                   neg_reg;
    logic [pdms_pkg::S2_BITS-1:0]           s2_reg;
    logic [pdms_pkg::DIV_BITS-1:0]          sq_reg;
    logic [pdms_pkg::DIV_BITS-1:0]          dq_reg;
    logic [pdms_pkg::N_BITS-1:0]            rem_reg;
    logic [pdms_pkg::N_BITS-1:0]            divisor_reg;
    logic [pdms_pkg::DIV_CNT_BITS-1:0]      cnt_reg;
    logic [pdms_pkg::SAMPLE_BITS-1:0]       mean_reg;
    logic [pdms_pkg::S2_BITS-1:0]           x_reg;
    logic [pdms_pkg::S2_BITS-1:0]           res_reg;
    logic [pdms_pkg::S2_BITS-1:0]           bit_reg;
    logic                                   out_valid_reg;
    logic [pdms_pkg::PIXEL_BITS-1:0]        out_pix_reg;
    logic [pdms_pkg::SAMPLE_BITS-1:0]       out_mean_reg;
    logic [pdms_pkg::SAMPLE_BITS-1:0]       out_std_reg;

    logic [pdms_pkg::N_BITS-1:0]            n_clamp;
    logic [pdms_pkg::S1_BITS-1:0]           abs_s1;
    logic [pdms_pkg::N_BITS:0]              rem_sh;
    logic                                   div_ge;
    logic [pdms_pkg::N_BITS-1:0]            rem_step;
    logic [pdms_pkg::DIV_BITS-1:0]          dq_step;
    logic signed [MEAN_BITS-1:0]            mean_s;
    logic [pdms_pkg::DIV_BITS-1:0]          s2_ext;
    logic [pdms_pkg::S2_BITS-1:0]           var_val;
    logic [pdms_pkg::S2_BITS:0]             sq_trial;
    logic                                   sq_ge;

    // Frame count clamped for the divisions.
    always_comb
    begin
        if (num_frames < pdms_pkg::N_BITS'(2))
        begin
            n_clamp = pdms_pkg::N_BITS'(2);
        end
        else if (num_frames > pdms_pkg::N_BITS'(pdms_pkg::MAX_FRAMES))
        begin
            n_clamp = pdms_pkg::N_BITS'(pdms_pkg::MAX_FRAMES);
        end
        else
        begin
            n_clamp = num_frames;
        end
    end

    assign abs_s1 = fifo_data.stats.s1[pdms_pkg::S1_BITS-1] ? -fifo_data.stats.s1
                                                            : fifo_data.stats.s1;

    // One restoring division step.
    always_comb
    begin
        rem_sh   = {rem_reg, dq_reg[pdms_pkg::DIV_BITS-1]};
        div_ge   = rem_sh >= {1'b0, divisor_reg};
        rem_step = div_ge ? pdms_pkg::N_BITS'(rem_sh - {1'b0, divisor_reg})
                          : rem_sh[pdms_pkg::N_BITS-1:0];
        dq_step  = {dq_reg[pdms_pkg::DIV_BITS-2:0], div_ge};
    end

    // Signed mean from the quotient magnitude.
    always_comb
    begin
        mean_s = neg_reg ? -$signed({2'b00, dq_reg[pdms_pkg::S1_BITS-1:0]})
                         : $signed({2'b00, dq_reg[pdms_pkg::S1_BITS-1:0]});
        mean_s = mean_s + $signed({{(MEAN_BITS-pdms_pkg::SAMPLE_BITS){1'b0}}, ref_reg});
    end

    // Variance numerator, floored at zero.
    always_comb
    begin
        s2_ext  = {{(pdms_pkg::DIV_BITS-pdms_pkg::S2_BITS){1'b0}}, s2_reg};
        var_val = (dq_reg > s2_ext) ? '0 : pdms_pkg::S2_BITS'(s2_ext - dq_reg);
    end

    // One square-root digit step.
    assign sq_trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign sq_ge    = {1'b0, x_reg} >= sq_trial;

    assign fifo_pop     = (state_reg == S_IDLE) && !fifo_empty;
    assign out_valid    = out_valid_reg;
    assign result_pixel = out_pix_reg;
    assign mean_value   = out_mean_reg;
    assign std_value    = out_std_reg;

    // Finalize sequencer and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pix_reg       <= '0;
            ref_reg       <= '0;
            neg_reg       <= 1'b0;
            s2_reg        <= '0;
            sq_reg        <= '0;
            dq_reg        <= '0;
            rem_reg       <= '0;
            divisor_reg   <= '0;
            cnt_reg       <= '0;
            mean_reg      <= '0;
            x_reg         <= '0;
            res_reg       <= '0;
            bit_reg       <= '0;
            out_pix_reg   <= '0;
            out_mean_reg  <= '0;
            out_std_reg   <= '0;
        end
        else
        begin
            // A taken result is dropped unless the finishing item refills the register.
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (!fifo_empty)
                    begin
                        pix_reg     <= fifo_data.pix;
                        ref_reg     <= fifo_data.stats.ref_val;
                        neg_reg     <= fifo_data.stats.s1[pdms_pkg::S1_BITS-1];
                        s2_reg      <= fifo_data.stats.s2;
                        sq_reg      <= abs_s1 * abs_s1;
                        dq_reg      <= {{(pdms_pkg::DIV_BITS-pdms_pkg::S1_BITS){1'b0}}, abs_s1};
                        rem_reg     <= '0;
                        divisor_reg <= n_clamp;
                        cnt_reg     <= '0;
                        state_reg   <= S_DIV_MEAN;
                    end
                end
                S_DIV_MEAN, S_DIV_Q, S_DIV_V:
                begin
                    dq_reg  <= dq_step;
                    rem_reg <= rem_step;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == pdms_pkg::DIV_CNT_BITS'(pdms_pkg::DIV_BITS - 1))
                    begin
                        case (state_reg)
                            S_DIV_MEAN: state_reg <= S_MEAN;
                            S_DIV_Q:    state_reg <= S_VAR;
                            default:    state_reg <= S_SQRT;
                        endcase
                        if (state_reg == S_DIV_V)
                        begin
                            x_reg   <= dq_step[pdms_pkg::S2_BITS-1:0];
                            res_reg <= '0;
                            bit_reg <= pdms_pkg::S2_BITS'(1) << (2 * (pdms_pkg::SQRT_STEPS - 1));
                            cnt_reg <= '0;
                        end
                    end
                end
                S_MEAN:
                begin
                    if (mean_s < 0)
                    begin
                        mean_reg <= '0;
                    end
                    else if (mean_s > $signed(MEAN_BITS'(16'hFFFF)))
                    begin
                        mean_reg <= '1;
                    end
                    else
                    begin
                        mean_reg <= mean_s[pdms_pkg::SAMPLE_BITS-1:0];
                    end
                    dq_reg    <= sq_reg;
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV_Q;
                end
                S_VAR:
                begin
                    dq_reg      <= {{(pdms_pkg::DIV_BITS-pdms_pkg::S2_BITS){1'b0}}, var_val};
                    rem_reg     <= '0;
                    divisor_reg <= n_clamp - 1'b1;
                    cnt_reg     <= '0;
                    state_reg   <= S_DIV_V;
                end
                S_SQRT:
                begin
                    if (sq_ge)
                    begin
                        x_reg   <= x_reg - sq_trial[pdms_pkg::S2_BITS-1:0];
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == pdms_pkg::DIV_CNT_BITS'(pdms_pkg::SQRT_STEPS - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_pix_reg   <= pix_reg;
                        out_mean_reg  <= mean_reg;
                        out_std_reg   <= (res_reg > pdms_pkg::S2_BITS'(16'hFFFF))
                                         ? '1 : res_reg[pdms_pkg::SAMPLE_BITS-1:0];
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MEAN) |-> (dq_reg[pdms_pkg::DIV_BITS-1:pdms_pkg::S1_BITS] == '0))
        else $error("mean quotient wider than the difference sum");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT) |-> (cnt_reg < pdms_pkg::DIV_CNT_BITS'(pdms_pkg::SQRT_STEPS)))
        else $error("square root ran past its last digit");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_MEAN || state_reg == S_DIV_Q || state_reg == S_DIV_V)
        |-> (rem_reg < divisor_reg))
        else $error("division remainder not below divisor");

endmodule

### design/pixel_dark_mean_std_accumulator_top.sv
// Accumulate items: one item per cycle while no finalize item is held by a full queue;
// the store is written in the cycle after acceptance. Finalize items run through the
// shared one-bit-per-cycle divider (three 56-step divisions) and the 21-step square
// root; a four-entry queue lets accumulate items keep flowing meanwhile.
// Reset is asynchronous and active low; it clears control state and sets the frame
// count to 2. Store contents are undefined until a first-frame item writes a pixel.
module pixel_dark_mean_std_accumulator_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pdms_pkg::N_BITS-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                op,
    input  logic [pdms_pkg::PIXEL_BITS-1:0]     pixel_index,
    input  logic [pdms_pkg::SAMPLE_BITS-1:0]    sample,
    input  logic                                first_frame,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pdms_pkg::PIXEL_BITS-1:0]     result_pixel,
    output logic [pdms_pkg::SAMPLE_BITS-1:0]    mean_value,
    output logic [pdms_pkg::SAMPLE_BITS-1:0]    std_value
);

    logic [pdms_pkg::N_BITS-1:0]    num_frames_reg;
    logic                           fifo_push;
    logic                           fifo_pop;
    logic                           fifo_full;
    logic                           fifo_empty;
    pdms_pkg::fin_entry_t           fifo_wr;
    pdms_pkg::fin_entry_t           fifo_rd;

    // Frame count register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_frames_reg <= pdms_pkg::N_BITS'(2);
        end
        else if (cfg_valid)
        begin
            num_frames_reg <= cfg_data;
        end
    end

    pdms_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .pixel_index (pixel_index),
        .sample      (sample),
        .first_frame (first_frame),
        .fifo_full   (fifo_full),
        .fifo_push   (fifo_push),
        .fifo_data   (fifo_wr)
    );

    pdms_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fifo_push),
        .wr_data (fifo_wr),
        .pop     (fifo_pop),
        .rd_data (fifo_rd),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    pdms_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .num_frames   (num_frames_reg),
        .fifo_empty   (fifo_empty),
        .fifo_data    (fifo_rd),
        .fifo_pop     (fifo_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_pixel (result_pixel),
        .mean_value   (mean_value),
        .std_value    (std_value)
    );

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 2000000;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [pdms_pkg::N_BITS-1:0]        cfg_data = '0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic                               op = 1'b0;
    logic [pdms_pkg::PIXEL_BITS-1:0]    pixel_index = '0;
    logic [pdms_pkg::SAMPLE_BITS-1:0]   sample = '0;
    logic                               first_frame = 1'b0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic [pdms_pkg::PIXEL_BITS-1:0]    result_pixel;
    logic [pdms_pkg::SAMPLE_BITS-1:0]   mean_value;
    logic [pdms_pkg::SAMPLE_BITS-1:0]   std_value;

    pixel_dark_mean_std_accumulator_top u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .pixel_index  (pixel_index),
        .sample       (sample),
        .first_frame  (first_frame),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_pixel (result_pixel),
        .mean_value   (mean_value),
        .std_value    (std_value)
    );

    // Clock with an 8 ns period.
    always #4 clk = ~clk;

    typedef struct {
        logic [pdms_pkg::PIXEL_BITS-1:0]    pix;
        logic [pdms_pkg::SAMPLE_BITS-1:0]   mean;
        logic [pdms_pkg::SAMPLE_BITS-1:0]   sd;
    } pixel_result_t;

    // Holds per-pixel sums and the queue of pixel statistics still to arrive.
    class pixel_stats_board;
        logic [pdms_pkg::SAMPLE_BITS-1:0]   ref_mem[pdms_pkg::PIXELS];
        logic [pdms_pkg::S1_BITS-1:0]       s1_mem[pdms_pkg::PIXELS];
        logic [pdms_pkg::S2_BITS-1:0]       s2_mem[pdms_pkg::PIXELS];
        int unsigned                        frames;
        pixel_result_t                      stats_q[$];
        int                                 errors;

        function new();
            frames = 2;
            errors = 0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > x)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (x >= res + bitv)
                begin
                    x = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function void note_input(logic o, logic [pdms_pkg::PIXEL_BITS-1:0] p,
                                 logic [pdms_pkg::SAMPLE_BITS-1:0] s, logic f);
            longint        d;
            longint        sq;
            longint        n;
            longint        s1;
            longint        mean;
            longint        var_v;
            longint unsigned a1;
            longint unsigned q;
            longint unsigned sd;
            pixel_result_t r;
            if (o == 1'b0)
            begin
                if (f)
                begin
                    ref_mem[p] = s;
                    s1_mem[p] = '0;
                    s2_mem[p] = '0;
                end
                else
                begin
                    d = longint'(s) - longint'(ref_mem[p]);
                    sq = d * d;
                    s1_mem[p] = s1_mem[p] + d[pdms_pkg::S1_BITS-1:0];
                    s2_mem[p] = s2_mem[p] + sq[pdms_pkg::S2_BITS-1:0];
                end
                return;
            end
            // Finalize: clamp N for the divisions only.
            n = frames;
            if (n < 2)
                n = 2;
            if (n > pdms_pkg::MAX_FRAMES)
                n = pdms_pkg::MAX_FRAMES;
            s1 = {{(64-pdms_pkg::S1_BITS){s1_mem[p][pdms_pkg::S1_BITS-1]}}, s1_mem[p]};
            mean = s1 / n + longint'(ref_mem[p]);
            if (mean < 0)
                mean = 0;
            if (mean > 65535)
                mean = 65535;
            a1 = (s1 < 0) ? -s1 : s1;
            q = (a1 * a1) / longint'(n);
            var_v = longint'({22'd0, s2_mem[p]}) - longint'(q);
            if (var_v < 0)
                var_v = 0;
            sd = int_sqrt(longint'(var_v) / (n - 1));
            if (sd > 65535)
                sd = 65535;
            r.pix = p;
            r.mean = mean[15:0];
            r.sd = sd[15:0];
            stats_q.push_back(r);
        endfunction

        function void check_result(logic [pdms_pkg::PIXEL_BITS-1:0] p,
                                   logic [pdms_pkg::SAMPLE_BITS-1:0] m,
                                   logic [pdms_pkg::SAMPLE_BITS-1:0] s);
            pixel_result_t e;
            if (stats_q.size() == 0)
            begin
                $error("result_pixel %0d arrived with nothing outstanding", p);
                errors++;
                return;
            end
            e = stats_q.pop_front();
            if (p !== e.pix)
            begin
                $error("result_pixel: expected %0d, got %0d", e.pix, p);
                errors++;
            end
            if (m !== e.mean)
            begin
                $error("mean_value: expected %0d, got %0d", e.mean, m);
                errors++;
            end
            if (s !== e.sd)
            begin
                $error("std_value: expected %0d, got %0d", e.sd, s);
                errors++;
            end
        endfunction

        function int pending();
            return stats_q.size();
        endfunction
    endclass

    pixel_stats_board board = new();

    bit             no_idle = 1'b0;
    int             rx_hold = 0;
    longint         cycles = 0;
    bit             pix_written[pdms_pkg::PIXELS];
    int             pool[8];
    int unsigned    cur_frames = 2;
    int             items_sent = 0;

    // Sample accepted items at the rising edge.
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            board.note_input(op, pixel_index, sample, first_frame);
        if (out_valid && out_ready)
            board.check_result(result_pixel, mean_value, std_value);
        if (cfg_valid && cfg_ready)
            board.frames = cfg_data;
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random back-pressure, or a long hold-off when asked.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_ready = 1'b0;
                rx_hold--;
            end
            else if (!no_idle && $urandom_range(99) < 10)
                out_ready = 1'b0;
            else
                out_ready = 1'b1;
        end
    end

    // Offer one item and wait for it to be accepted. Called at a falling edge,
    // so consecutive calls present items back to back unless a random idle gap is inserted.
    task automatic send_item(logic o, int p, int s, logic f);
        while (!no_idle && $urandom_range(99) < 10)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        op = o;
        pixel_index = p[pdms_pkg::PIXEL_BITS-1:0];
        sample = s[pdms_pkg::SAMPLE_BITS-1:0];
        first_frame = f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (o == 1'b0 && f)
            pix_written[p] = 1'b1;
        items_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Wait for every result, then let the pipeline drain before a register write.
    task automatic drain();
        while (board.pending() > 0)
            @(negedge clk);
        repeat (250) @(negedge clk);
    endtask

    task automatic write_frames(int unsigned v);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = v[pdms_pkg::N_BITS-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cur_frames = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic int pick_sample(int refv);
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return 0;
        if (r < 30)
            return 65535;
        if (r < 70)
        begin
            r = refv + $urandom_range(64) - 32;
            return (r < 0) ? 0 : ((r > 65535) ? 65535 : r);
        end
        return $urandom_range(65535);
    endfunction

    // A phase of random traffic over a small pool of pixels.
    task automatic random_phase(int count);
        int stop;
        int p;
        int refv;
        int len;
        int r;
        stop = items_sent + count;
        for (int i = 0; i < 8; i++)
            pool[i] = $urandom_range(pdms_pkg::PIXELS - 1);
        while (items_sent < stop)
        begin
            p = pool[$urandom_range(7)];
            r = $urandom_range(99);
            if (r < 55)
            begin
                // Well-formed frame series: reference, N-1 samples when N is 2 to 12 (else 1 to 12), finalize.
                refv = $urandom_range(65535);
                len = (cur_frames > 1 && cur_frames < 13) ? cur_frames - 1 :
                      $urandom_range(12, 1);
                send_item(1'b0, p, refv, 1'b1);
                for (int k = 0; k < len; k++)
                    send_item(1'b0, p, pick_sample(refv), 1'b0);
                send_item(1'b1, p, $urandom_range(65535), 1'($urandom_range(1)));
            end
            else if (r < 62)
            begin
                send_item(1'b0, $urandom_range(pdms_pkg::PIXELS - 1), $urandom_range(65535),
                          1'b1);
            end
            else if (!pix_written[p])
            begin
                send_item(1'b0, p, $urandom_range(65535), 1'b1);
            end
            else if (r < 85)
            begin
                send_item(1'b0, p, pick_sample($urandom_range(65535)), 1'b0);
            end
            else
            begin
                send_item(1'b1, p, $urandom_range(65535), 1'($urandom_range(1)));
            end
        end
    endtask

    int unsigned frame_settings[8] = '{2, 1024, 0, 3, 2047, 16, 1, 5};

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed items with the frame count left at its reset value.
        send_item(1'b0, 0, 0, 1'b1);
        send_item(1'b0, 0, 65535, 1'b0);
        send_item(1'b1, 0, 0, 1'b0);
        send_item(1'b1, 0, 65535, 1'b1);
        send_item(1'b0, 4095, 65535, 1'b1);
        send_item(1'b0, 4095, 0, 1'b0);
        send_item(1'b0, 4095, 0, 1'b0);
        send_item(1'b1, 4095, 0, 1'b0);
        // Mean saturates high.
        send_item(1'b0, 5, 60000, 1'b1);
        repeat (3) send_item(1'b0, 5, 65535, 1'b0);
        send_item(1'b1, 5, 0, 1'b0);
        // Mean below zero, and more samples than N so the variance goes negative.
        send_item(1'b0, 6, 1000, 1'b1);
        repeat (4) send_item(1'b0, 6, 0, 1'b0);
        send_item(1'b1, 6, 0, 1'b0);
        // Standard deviation saturates.
        send_item(1'b0, 7, 32768, 1'b1);
        for (int k = 0; k < 6; k++)
            send_item(1'b0, 7, (k % 2) ? 65535 : 1, 1'b0);
        send_item(1'b1, 7, 0, 1'b0);

        foreach (frame_settings[i])
        begin
            drain();
            write_frames(frame_settings[i]);
            if (i == 3)
            begin
                // Long receiver hold-off while finalize items pile up.
                rx_hold = 3000;
                for (int k = 0; k < 12; k++)
                    send_item(1'b1, (k % 2) ? 4095 : 0, $urandom_range(65535), 1'b0);
            end
            no_idle = (i == 5);
            random_phase(125);
            no_idle = 1'b0;
        end

        while (board.pending() > 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
design/pdms_pkg.sv
design/pdms_fifo.sv
design/pdms_front.sv
design/pdms_back.sv
design/pixel_dark_mean_std_accumulator_top.sv
dv/tb_top.sv
